>>> hw/rtl/cem_pkg.sv
// ----------------------------------------------------------------------------
// cem_pkg: shared types, constants and helpers for the cron expression matcher
// parser phase codes, token flag bits, field bounds and number accumulation
// ----------------------------------------------------------------------------
package cem_pkg;

    // buffer limits of the expression and of one field
    localparam int unsigned EXPR_BUFFER  = 64;
    localparam int unsigned FIELD_BUFFER = 48;

    localparam int unsigned EXPR_LEN_W  = $clog2(EXPR_BUFFER + 1);
    localparam int unsigned FIELD_LEN_W = $clog2(FIELD_BUFFER + 1);

    localparam logic [EXPR_LEN_W-1:0]  EXPR_LIMIT  = EXPR_LEN_W'(EXPR_BUFFER);
    localparam logic [FIELD_LEN_W-1:0] FIELD_LIMIT = FIELD_LEN_W'(FIELD_BUFFER);

    localparam logic [2:0] NUM_FIELDS = 3'd5;

    typedef logic [2:0] phase_t;
    typedef logic [3:0] flags_t;
    typedef logic [7:0] num_t;

    // token phases
    localparam phase_t PH_START  = 3'd0;
    localparam phase_t PH_STAR   = 3'd1;
    localparam phase_t PH_FIRST  = 3'd2;
    localparam phase_t PH_SECOND = 3'd3;
    localparam phase_t PH_STEP   = 3'd4;
    localparam phase_t PH_BAD    = 3'd5;

    // token flag bit positions
    localparam int unsigned FL_STAR      = 0;
    localparam int unsigned FL_RANGE     = 1;
    localparam int unsigned FL_END_SEEN  = 2;
    localparam int unsigned FL_STEP_SEEN = 3;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // acc * 10 + d, saturating at 255
    function automatic num_t add_digit(input num_t acc, input logic [3:0] d);
        logic [11:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, d};
        add_digit = (v > 12'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic num_t field_lo(input logic [2:0] idx);
        case (idx)
            3'd2:    field_lo = 8'd1;
            3'd3:    field_lo = 8'd1;
            default: field_lo = 8'd0;
        endcase
    endfunction

    function automatic num_t field_hi(input logic [2:0] idx);
        case (idx)
            3'd0:    field_hi = 8'd59;
            3'd1:    field_hi = 8'd23;
            3'd2:    field_hi = 8'd31;
            3'd3:    field_hi = 8'd12;
            3'd4:    field_hi = 8'd6;
            default: field_hi = 8'd0;
        endcase
    endfunction

endpackage

>>> hw/rtl/cron_expression_matcher_top.sv
// ----------------------------------------------------------------------------
// cron_expression_matcher_top: streaming five-field cron expression matcher
// parses one character per word and reports a match bit on the final word
// ----------------------------------------------------------------------------
// The block takes a cron expression one character per input word, with the
// calendar time (minute, hour, day of month, month, day of week) on the same
// word; the time is latched with every word. Fields split on runs of space or
// tab, tokens on commas; a token is '*', N or N-M with an optional /S. Bad or
// out-of-range tokens are skipped, a field matches if any token hits, and all
// five fields must match. A word with last_char set produces one output word
// with matches_res; no other word produces output. Sequence: a character is
// accepted, then parsed in a parse state. A comma or field separator adds a
// bounds-check state per token and, when the token range holds the time
// value, the step remainder in the shared bit-serial subtract unit; a field
// close adds a bookkeeping state. The final word adds the end-of-expression
// state, the close of any open field as above, and a state to load the
// result register, longer if that register is still waiting on out_ready.
// in_ready is high only while the sequencer is idle.
module cron_expression_matcher_top
    import cem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input word
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       last_char,
    input  logic [5:0] minute,
    input  logic [4:0] hour,
    input  logic [4:0] day_of_month,
    input  logic [3:0] month,
    input  logic [2:0] day_of_week,
    // result word
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matches_res
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a word
    localparam logic [2:0] S_CHAR = 3'd1;  // parse the latched character
    localparam logic [2:0] S_END  = 3'd2;  // end of expression, close open field
    localparam logic [2:0] S_TOK  = 3'd3;  // bounds check of the closing token
    localparam logic [2:0] S_REM  = 3'd4;  // step remainder, one bit per cycle
    localparam logic [2:0] S_FLD  = 3'd5;  // field bookkeeping
    localparam logic [2:0] S_RES  = 3'd6;  // load result register

    localparam int unsigned DIV_BITS = 6;
    localparam logic [2:0] DIV_LAST = 3'(DIV_BITS - 1);

    // latched input word
    logic [7:0] char_reg;
    logic       last_reg;
    logic [5:0] minute_reg;
    logic [4:0] hour_reg;
    logic [4:0] dom_reg;
    logic [3:0] month_reg;
    logic [2:0] dow_reg;

    // sequencer and parser state
    logic [2:0]             state_reg, state_next;
    logic [2:0]             field_count_reg, field_count_next;
    logic                   all_ok_reg, all_ok_next;
    logic                   field_hit_reg, field_hit_next;
    logic [EXPR_LEN_W-1:0]  expr_len_reg, expr_len_next;
    logic [FIELD_LEN_W-1:0] field_len_reg, field_len_next;
    phase_t                 phase_reg, phase_next;
    flags_t                 flags_reg, flags_next;
    num_t                   rstart_reg, rstart_next;
    num_t                   rend_reg, rend_next;
    num_t                   step_reg, step_next;
    logic                   close_field_reg, close_field_next;
    logic                   from_end_reg, from_end_next;
    logic                   lone_star_reg, lone_star_next;

    // shared remainder unit
    logic [5:0] dvd_reg, dvd_next;
    num_t       div_reg, div_next;
    num_t       rem_reg, rem_next;
    logic [2:0] iter_reg, iter_next;

    logic out_valid_reg, out_valid_next;
    logic match_reg, match_next;

    logic       accept;
    logic       is_digit;
    logic       is_sep;
    logic [3:0] digit;
    logic [2:0] after_close;
    logic [5:0] tval;
    num_t       tval8;
    num_t       lo;
    num_t       hi;
    num_t       s_val;
    num_t       e_val;
    num_t       step_use;
    num_t       diff;
    logic       step_ok;
    logic       end_ok;
    logic       eligible;
    logic       in_range;
    logic [8:0] trial;
    logic [8:0] trial_sub;
    num_t       rem_new;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign matches_res = match_reg;

    // input word capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg   <= char_code;
            last_reg   <= last_char;
            minute_reg <= minute;
            hour_reg   <= hour;
            dom_reg    <= day_of_month;
            month_reg  <= month;
            dow_reg    <= day_of_week;
        end
    end

    // character classes; for '0'..'9' the low nibble is the digit value
    assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign is_sep   = (char_reg == CH_SPACE) || (char_reg == CH_TAB);
    assign digit    = char_reg[3:0];

    // where to go once a token or field close is done
    assign after_close = from_end_reg ? S_RES : (last_reg ? S_END : S_IDLE);

    // time value of the current field
    always_comb
    begin
        case (field_count_reg)
            3'd0:    tval = minute_reg;
            3'd1:    tval = {1'b0, hour_reg};
            3'd2:    tval = {1'b0, dom_reg};
            3'd3:    tval = {2'b00, month_reg};
            3'd4:    tval = {3'b000, dow_reg};
            default: tval = 6'd0;
        endcase
    end

    // token bounds check, used in the token-check cycle
    assign tval8 = {2'b00, tval};
    assign lo    = field_lo(field_count_reg);
    assign hi    = field_hi(field_count_reg);

    always_comb
    begin
        step_ok  = 1'b1;
        step_use = 8'd1;
        end_ok   = 1'b1;
        if (phase_reg == PH_STEP)
        begin
            if (!flags_reg[FL_STEP_SEEN] || (step_reg == 8'd0))
                step_ok = 1'b0;
            else
                step_use = step_reg;
        end
        if (flags_reg[FL_STAR])
        begin
            s_val = lo;
            e_val = hi;
        end
        else if (flags_reg[FL_RANGE])
        begin
            end_ok = flags_reg[FL_END_SEEN];
            s_val  = rstart_reg;
            e_val  = rend_reg;
        end
        else
        begin
            s_val = rstart_reg;
            e_val = rstart_reg;
        end
    end

    assign eligible = (field_count_reg < NUM_FIELDS) && (phase_reg != PH_START)
                      && (phase_reg != PH_BAD);
    assign in_range = step_ok && end_ok && (s_val >= lo) && (e_val <= hi)
                      && (s_val <= e_val) && (tval8 >= s_val) && (tval8 <= e_val);
    assign diff     = tval8 - s_val;

    // restoring remainder step
    assign trial     = {rem_reg, dvd_reg[5]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign rem_new   = (trial >= {1'b0, div_reg}) ? trial_sub[7:0] : trial[7:0];

    always_comb
    begin
        state_next       = state_reg;
        field_count_next = field_count_reg;
        all_ok_next      = all_ok_reg;
        field_hit_next   = field_hit_reg;
        expr_len_next    = expr_len_reg;
        field_len_next   = field_len_reg;
        phase_next       = phase_reg;
        flags_next       = flags_reg;
        rstart_next      = rstart_reg;
        rend_next        = rend_reg;
        step_next        = step_reg;
        close_field_next = close_field_reg;
        from_end_next    = from_end_reg;
        lone_star_next   = lone_star_reg;
        dvd_next         = dvd_reg;
        div_next         = div_reg;
        rem_next         = rem_reg;
        iter_next        = iter_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        match_next       = match_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHAR;
            end

            S_CHAR:
            begin
                state_next = last_reg ? S_END : S_IDLE;
                if (char_reg != CH_NUL)
                begin
                    if (expr_len_reg < EXPR_LIMIT)
                        expr_len_next = expr_len_reg + 1'b1;
                    if (is_sep)
                    begin
                        if (field_len_reg != '0)
                        begin
                            close_field_next = 1'b1;
                            from_end_next    = 1'b0;
                            lone_star_next   = (field_len_reg == FIELD_LEN_W'(1))
                                               && (phase_reg == PH_STAR);
                            state_next       = S_TOK;
                        end
                    end
                    else
                    begin
                        if (field_len_reg < FIELD_LIMIT)
                            field_len_next = field_len_reg + 1'b1;
                        if (char_reg == CH_COMMA)
                        begin
                            close_field_next = 1'b0;
                            from_end_next    = 1'b0;
                            state_next       = S_TOK;
                        end
                        else
                        begin
                            // token grammar
                            case (phase_reg)
                                PH_START:
                                begin
                                    if (is_digit)
                                    begin
                                        rstart_next = {4'h0, digit};
                                        phase_next  = PH_FIRST;
                                    end
                                    else if (char_reg == CH_STAR)
                                    begin
                                        flags_next[FL_STAR] = 1'b1;
                                        phase_next          = PH_STAR;
                                    end
                                    else
                                        phase_next = PH_BAD;
                                end
                                PH_STAR:
                                begin
                                    phase_next = (char_reg == CH_SLASH) ? PH_STEP : PH_BAD;
                                end
                                PH_FIRST:
                                begin
                                    if (is_digit)
                                        rstart_next = add_digit(rstart_reg, digit);
                                    else if (char_reg == CH_DASH)
                                    begin
                                        flags_next[FL_RANGE] = 1'b1;
                                        phase_next           = PH_SECOND;
                                    end
                                    else if (char_reg == CH_SLASH)
                                        phase_next = PH_STEP;
                                    else
                                        phase_next = PH_BAD;
                                end
                                PH_SECOND:
                                begin
                                    if (is_digit)
                                    begin
                                        rend_next               = add_digit(rend_reg, digit);
                                        flags_next[FL_END_SEEN] = 1'b1;
                                    end
                                    else if (char_reg == CH_SLASH)
                                        phase_next = PH_STEP;
                                    else
                                        phase_next = PH_BAD;
                                end
                                PH_STEP:
                                begin
                                    if (is_digit)
                                    begin
                                        step_next                = add_digit(step_reg, digit);
                                        flags_next[FL_STEP_SEEN] = 1'b1;
                                    end
                                    else
                                        phase_next = PH_BAD;
                                end
                                default:
                                begin
                                    phase_next = PH_BAD;
                                end
                            endcase
                        end
                    end
                end
            end

            S_END:
            begin
                if (field_len_reg != '0)
                begin
                    close_field_next = 1'b1;
                    from_end_next    = 1'b1;
                    lone_star_next   = (field_len_reg == FIELD_LEN_W'(1))
                                       && (phase_reg == PH_STAR);
                    state_next       = S_TOK;
                end
                else
                begin
                    state_next = S_RES;
                end
            end

            S_TOK:
            begin
                if (eligible && in_range)
                begin
                    // hand (value - start) mod step to the remainder unit
                    dvd_next   = diff[5:0];
                    div_next   = step_use;
                    rem_next   = 8'd0;
                    iter_next  = 3'd0;
                    state_next = S_REM;
                end
                else
                begin
                    phase_next  = PH_START;
                    flags_next  = '0;
                    rstart_next = 8'd0;
                    rend_next   = 8'd0;
                    step_next   = 8'd0;
                    state_next  = close_field_reg ? S_FLD : after_close;
                end
            end

            S_REM:
            begin
                rem_next  = rem_new;
                dvd_next  = {dvd_reg[4:0], 1'b0};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == DIV_LAST)
                begin
                    if (rem_new == 8'd0)
                        field_hit_next = 1'b1;
                    phase_next  = PH_START;
                    flags_next  = '0;
                    rstart_next = 8'd0;
                    rend_next   = 8'd0;
                    step_next   = 8'd0;
                    state_next  = close_field_reg ? S_FLD : after_close;
                end
            end

            S_FLD:
            begin
                if (field_count_reg < NUM_FIELDS)
                begin
                    if ((field_len_reg >= FIELD_LIMIT) || (!lone_star_reg && !field_hit_reg))
                        all_ok_next = 1'b0;
                    field_count_next = field_count_reg + 1'b1;
                end
                field_len_next = '0;
                field_hit_next = 1'b0;
                state_next     = after_close;
            end

            S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    match_next       = all_ok_reg && (field_count_reg == NUM_FIELDS)
                                       && (expr_len_reg < EXPR_LIMIT);
                    // back to the reset state for the next expression
                    field_count_next = 3'd0;
                    all_ok_next      = 1'b1;
                    field_hit_next   = 1'b0;
                    expr_len_next    = '0;
                    field_len_next   = '0;
                    phase_next       = PH_START;
                    flags_next       = '0;
                    rstart_next      = 8'd0;
                    rend_next        = 8'd0;
                    step_next        = 8'd0;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            field_count_reg <= 3'd0;
            all_ok_reg      <= 1'b1;
            field_hit_reg   <= 1'b0;
            expr_len_reg    <= '0;
            field_len_reg   <= '0;
            phase_reg       <= PH_START;
            flags_reg       <= '0;
            rstart_reg      <= 8'd0;
            rend_reg        <= 8'd0;
            step_reg        <= 8'd0;
            close_field_reg <= 1'b0;
            from_end_reg    <= 1'b0;
            lone_star_reg   <= 1'b0;
            iter_reg        <= 3'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            field_count_reg <= field_count_next;
            all_ok_reg      <= all_ok_next;
            field_hit_reg   <= field_hit_next;
            expr_len_reg    <= expr_len_next;
            field_len_reg   <= field_len_next;
            phase_reg       <= phase_next;
            flags_reg       <= flags_next;
            rstart_reg      <= rstart_next;
            rend_reg        <= rend_next;
            step_reg        <= step_next;
            close_field_reg <= close_field_next;
            from_end_reg    <= from_end_next;
            lone_star_reg   <= lone_star_next;
            iter_reg        <= iter_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // remainder datapath and result payload
    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        match_reg <= match_next;
    end

`ifndef SYNTHESIS
    // field counter never passes the number of checked fields
    a_field_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        field_count_reg <= NUM_FIELDS)
        else $error("field count beyond five");

    // remainder unit runs a bounded number of iterations
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REM) |-> (iter_reg <= DIV_LAST))
        else $error("remainder iteration overrun");

    // a result word is only loaded from the result state
    a_out_from_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_RES))
        else $error("result word loaded outside result state");

    // after loading a result the parser is back in its reset state
    a_clean_after_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (state_reg == S_IDLE) && (field_count_reg == 3'd0)
                                 && (expr_len_reg == '0) && all_ok_reg)
        else $error("parser state not cleared after result");

    // a divide is only started for a token that is being closed
    a_rem_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REM) && (iter_reg == 3'd0) |-> ($past(state_reg) == S_TOK))
        else $error("remainder unit started without token check");
`endif

endmodule
